// ----- rtl/modular_exponentiation_top_macros.svh -----
// Assertion macros shared by the modular exponentiation RTL.
// Both assume a clock named clk_i and an active-low reset named rst_ni.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MEXP_ASSERT(lbl, prop, msg)
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/mexp_pkg.sv -----
`default_nettype none

package mexp_pkg;

  // Width of every field on the ports.
  localparam int unsigned DATA_W = 32;

  // Default operand width; the low WORD_BITS bits of each field are used.
  localparam int unsigned WORD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_GO,
    S_RED_WAIT,
    S_SQR_GO,
    S_SQR_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_FINISH
  } mexp_state_e;

  // Control from the sequencer to the modular multiplier.
  typedef struct packed {
    logic start;
  } mm_ctrl_t;

  // Status from the modular multiplier back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

`default_nettype wire

// ----- rtl/modular_exponentiation_top.sv -----
// One item is in flight at a time: the input is taken only while the sequencer is idle.
// A zero modulus or a zero exponent goes straight from the input transfer to the finish state.
// Each modular multiply runs a launch, WORD_BITS steps and a done strobe.
// A full, stalled output register holds the sequencer in its finish state, which delays
// the next input transfer.
// Reset clears the sequencer and the output valid flag; data registers are not reset.
`default_nettype none
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top #(
  parameter int unsigned WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [mexp_pkg::DATA_W-1:0] exponent_i,
  input  wire logic [mexp_pkg::DATA_W-1:0] message_i,
  input  wire logic [mexp_pkg::DATA_W-1:0] modulus_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [mexp_pkg::DATA_W-1:0]      result_o,
  output logic                             error_o
);
  import mexp_pkg::*;

  localparam int unsigned BitW = $clog2(WORD_BITS);

  mexp_state_e state_q, state_d;

  logic [WORD_BITS-1:0] exp_q, exp_d;
  logic [WORD_BITS-1:0] base_q, base_d;
  logic [WORD_BITS-1:0] mod_q, mod_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [BitW-1:0]      bit_q, bit_d;
  logic                 err_q, err_d;

  logic                 out_valid_q, out_valid_d;
  logic [DATA_W-1:0]    out_result_q;
  logic                 out_error_q;

  logic [WORD_BITS-1:0] in_exp, in_msg, in_mod;
  logic                 in_xfer, out_xfer, out_free;

  mm_ctrl_t             mm_ctrl;
  mm_stat_t             mm_stat;
  logic [WORD_BITS-1:0] mm_a, mm_b, mm_res;
  logic                 load_out;

  assign in_exp   = exponent_i[WORD_BITS-1:0];
  assign in_msg   = message_i[WORD_BITS-1:0];
  assign in_mod   = modulus_i[WORD_BITS-1:0];
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (in_mod == '0 || in_exp == '0) ? S_FINISH : S_RED_GO;
        end
      end
      S_RED_GO:   state_d = S_RED_WAIT;
      S_RED_WAIT: begin
        if (mm_stat.done) begin
          state_d = S_SQR_GO;
        end
      end
      S_SQR_GO:   state_d = S_SQR_WAIT;
      S_SQR_WAIT: begin
        if (mm_stat.done) begin
          if (exp_q[bit_q]) begin
            state_d = S_MUL_GO;
          end else begin
            state_d = (bit_q == '0) ? S_FINISH : S_SQR_GO;
          end
        end
      end
      S_MUL_GO:   state_d = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mm_stat.done) begin
          state_d = (bit_q == '0) ? S_FINISH : S_SQR_GO;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: input stall, multiplier launch, operand choice, output load.
  always_comb begin
    mm_ctrl.start = 1'b0;
    mm_a          = acc_q;
    mm_b          = base_q;
    load_out      = 1'b0;
    in_stall_o    = 1'b1;
    unique case (state_q)
      S_IDLE: in_stall_o = 1'b0;
      S_RED_GO: begin
        // base mod m, computed as 1 * base.
        mm_ctrl.start = 1'b1;
        mm_a          = {{(WORD_BITS-1){1'b0}}, 1'b1};
        mm_b          = base_q;
      end
      S_SQR_GO: begin
        mm_ctrl.start = 1'b1;
        mm_a          = acc_q;
        mm_b          = acc_q;
      end
      S_MUL_GO: begin
        mm_ctrl.start = 1'b1;
        mm_a          = acc_q;
        mm_b          = base_q;
      end
      S_FINISH: load_out = out_free;
      default: begin
      end
    endcase
  end

  // Operand and accumulator registers.
  always_comb begin
    exp_d  = exp_q;
    base_d = base_q;
    mod_d  = mod_q;
    acc_d  = acc_q;
    bit_d  = bit_q;
    err_d  = err_q;
    if (in_xfer) begin
      exp_d  = in_exp;
      base_d = in_msg;
      mod_d  = in_mod;
      err_d  = (in_mod == '0);
      // A zero modulus gives 0, a zero exponent gives 1 unreduced.
      acc_d  = (in_mod == '0) ? '0 : {{(WORD_BITS-1){1'b0}}, 1'b1};
    end
    if (mm_stat.done) begin
      if (state_q == S_RED_WAIT) begin
        base_d = mm_res;
        // The running product starts at 1 mod m, which is 0 when m is 1.
        acc_d  = (mod_q == {{(WORD_BITS-1){1'b0}}, 1'b1}) ? '0
                                                           : {{(WORD_BITS-1){1'b0}}, 1'b1};
        bit_d  = BitW'(WORD_BITS - 1);
      end else begin
        acc_d = mm_res;
        if ((state_q == S_SQR_WAIT && !exp_q[bit_q]) || state_q == S_MUL_WAIT) begin
          if (bit_q != '0) begin
            bit_d = bit_q - 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    base_q <= base_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    err_q  <= err_d;
    if (load_out) begin
      out_result_q <= DATA_W'(acc_q);
      out_error_q  <= err_q;
    end
  end

  mexp_modmul #(
    .WORD_BITS (WORD_BITS)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mm_ctrl),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .m_i    (mod_q),
    .stat_o (mm_stat),
    .res_o  (mm_res)
  );

  assign out_valid_o = out_valid_q;
  assign result_o    = out_result_q;
  assign error_o     = out_error_q;

  `MEXP_ASSERT(a_done_when_waiting, mm_stat.done |-> (state_q == S_RED_WAIT || state_q == S_SQR_WAIT || state_q == S_MUL_WAIT), "multiplier finished outside a wait state")
  `MEXP_ASSERT(a_acc_reduced, (state_q == S_SQR_GO || state_q == S_MUL_GO) |-> acc_q < mod_q && base_q < mod_q, "multiplier operand not reduced")
  `MEXP_ASSERT(a_launch_when_idle, mm_ctrl.start |-> !mm_stat.busy, "multiplier launched while busy")
  `MEXP_ASSERT(a_out_drains, out_xfer && state_q != S_FINISH |=> !out_valid_q, "result register did not empty after transfer")
  `MEXP_ASSERT_ALWAYS(a_error_zero, out_valid_q && out_error_q |-> out_result_q == '0, "error result not zero")

endmodule

`default_nettype wire

// ----- rtl/mexp_modmul.sv -----
`default_nettype none
`include "modular_exponentiation_top_macros.svh"

// Interleaved shift-and-add modular multiplier: one bit of b per cycle,
// most significant first. Needs a < m and m nonzero; b may be any value.
module mexp_modmul #(
  parameter int unsigned WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mexp_pkg::mm_ctrl_t   ctrl_i,
  input  wire logic [WORD_BITS-1:0] a_i,
  input  wire logic [WORD_BITS-1:0] b_i,
  input  wire logic [WORD_BITS-1:0] m_i,
  output mexp_pkg::mm_stat_t        stat_o,
  output logic [WORD_BITS-1:0]      res_o
);
  import mexp_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_BITS);
  localparam int unsigned ExtW = WORD_BITS + 3;

  logic [WORD_BITS-1:0] a_q, b_q, m_q, r_q;
  logic [WORD_BITS-1:0] b_d, r_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [ExtW-1:0] sum_ext;
  logic [ExtW-1:0] diff1;
  logic [ExtW-1:0] diff2;
  logic [ExtW-1:0] m_ext;

  // 2r + a stays below 3m, so at most 2m has to come off.
  always_comb begin
    m_ext   = {3'b000, m_q};
    sum_ext = {2'b00, r_q, 1'b0} + (b_q[WORD_BITS-1] ? {3'b000, a_q} : '0);
    diff1   = sum_ext - m_ext;
    diff2   = sum_ext - {m_ext[ExtW-2:0], 1'b0};
  end

  always_comb begin
    b_d    = b_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      b_d    = b_i;
      r_d    = '0;
      cnt_d  = CntW'(WORD_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      b_d = {b_q[WORD_BITS-2:0], 1'b0};
      if (!diff2[ExtW-1]) begin
        r_d = diff2[WORD_BITS-1:0];
      end else if (!diff1[ExtW-1]) begin
        r_d = diff1[WORD_BITS-1:0];
      end else begin
        r_d = sum_ext[WORD_BITS-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q <= a_i;
      m_q <= m_i;
    end
    b_q <= b_d;
    r_q <= r_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = r_q;

  `MEXP_ASSERT(a_start_loads, ctrl_i.start |=> busy_q && cnt_q == CntW'(WORD_BITS - 1), "multiplier did not start")
  `MEXP_ASSERT(a_last_step_done, busy_q && !ctrl_i.start && cnt_q == '0 |=> done_q && !busy_q, "multiplier did not finish after its last step")
  `MEXP_ASSERT(a_rem_below_mod, busy_q |-> r_q < m_q, "partial remainder not reduced")

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mexp_pkg::*;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned WORD_BITS = WORD_BITS_DEF;
  // The longest item takes (1 + 2 * WORD_BITS) modular multiplies.
  localparam int unsigned ITEM_LATENCY = (1 + 2 * WORD_BITS) * (WORD_BITS + 2) + 2;
  // Long enough to finish the item in progress and the next one, so the input backs up.
  localparam int unsigned HOLD_CYCLES = 3 * ITEM_LATENCY;
  localparam int unsigned QUIET_LIMIT = 4 * (ITEM_LATENCY + HOLD_CYCLES + 100);
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_PER_PHASE = 84;

  class powmod_scoreboard;
    typedef struct {
      logic [DATA_W-1:0] result;
      logic              error;
    } powmod_t;

    powmod_t     expected_powers[$];
    int unsigned failures = 0;

    // Right-to-left square-and-multiply; products stay below 2^64, so nothing wraps.
    function powmod_t modpow(logic [DATA_W-1:0] ex_in, logic [DATA_W-1:0] base_in,
                             logic [DATA_W-1:0] n_in);
      powmod_t     r;
      logic [63:0] mask;
      logic [63:0] ex;
      logic [63:0] n;
      logic [63:0] acc;
      logic [63:0] sq;
      int          i;
      mask = (64'd1 << WORD_BITS) - 64'd1;
      ex = ex_in & mask;
      n = n_in & mask;
      sq = base_in & mask;
      if (n == 64'd0) begin
        r.result = '0;
        r.error = 1'b1;
      end else if (ex == 64'd0) begin
        // A zero exponent gives one without reduction, even for a modulus of one.
        r.result = DATA_W'(1);
        r.error = 1'b0;
      end else begin
        acc = 64'd1 % n;
        sq = sq % n;
        for (i = 0; i < WORD_BITS; i++) begin
          if (ex[i]) begin
            acc = (acc * sq) % n;
          end
          sq = (sq * sq) % n;
        end
        r.result = acc[DATA_W-1:0];
        r.error = 1'b0;
      end
      return r;
    endfunction

    function void note_operands(logic [DATA_W-1:0] ex, logic [DATA_W-1:0] msg,
                                logic [DATA_W-1:0] n);
      expected_powers.push_back(modpow(ex, msg, n));
    endfunction

    function void check_result(logic [DATA_W-1:0] result, logic error);
      powmod_t want;
      if (expected_powers.size() == 0) begin
        $error("result transfer with none outstanding: result %0h error %0b", result, error);
        failures++;
      end else begin
        want = expected_powers.pop_front();
        if (result !== want.result) begin
          $error("field result: expected %0h, actual %0h", want.result, result);
          failures++;
        end
        if (error !== want.error) begin
          $error("field error: expected %0b, actual %0b", want.error, error);
          failures++;
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [DATA_W-1:0] exponent_i = '0;
  logic [DATA_W-1:0] message_i = '0;
  logic [DATA_W-1:0] modulus_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DATA_W-1:0] result_o;
  logic              error_o;

  int unsigned sender_idle_pct = 12;
  int unsigned receiver_idle_pct = 76;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  powmod_scoreboard sb = new();

  modular_exponentiation_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .exponent_i  (exponent_i),
    .message_i   (message_i),
    .modulus_i   (modulus_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .error_o     (error_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic send_operands(input logic [DATA_W-1:0] ex, input logic [DATA_W-1:0] msg,
                               input logic [DATA_W-1:0] n);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    exponent_i <= ex;
    message_i <= msg;
    modulus_i <= n;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    sb.note_operands(ex, msg, n);
  endtask

  task automatic send_random_operands();
    int unsigned       kind;
    logic [DATA_W-1:0] ex;
    logic [DATA_W-1:0] msg;
    logic [DATA_W-1:0] n;
    kind = $urandom_range(99);
    ex = $urandom();
    msg = $urandom();
    n = $urandom();
    if (kind < 12) begin
      n = $urandom_range(255, 1);
    end else if (kind < 18) begin
      ex = '0;
    end else if (kind < 24) begin
      n = '0;
    end else if (kind < 30) begin
      // A short exponent keeps the multiply count low.
      ex = $urandom_range(15, 1);
    end else if (kind < 36) begin
      n = {1'b1, n[DATA_W-2:0]};
      msg = n + $urandom_range(1000);
    end
    send_operands(ex, msg, n);
  endtask

  // Result side: checks each transfer and stalls at random or for one long hold-off.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(result_o, error_o);
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero modulus, with and without an exponent.
    send_operands('0, 32'd5, '0);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    // Zero exponent: one, unreduced even for a modulus of one.
    send_operands('0, 32'd7, 32'd1);
    send_operands('0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'd9, 32'd123, 32'd1);
    send_operands(32'd1, 32'd1000, 32'd7);
    send_operands(32'd3, 32'd11, 32'd11);
    send_operands(32'd5, 32'd0, 32'd97);
    send_operands(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFB);
    send_operands(32'd17, 32'd65, 32'd3233);
    send_operands(32'd2753, 32'd2790, 32'd3233);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001);
    send_operands(32'h8000_0000, 32'd3, 32'd2);
    send_operands(32'd2, 32'hFFFF_FFFF, 32'd3);
    send_operands(32'h0001_0001, 32'h7FFF_FFFF, 32'hFFFF_FFC5);

    repeat (RANDOM_PER_PHASE) send_random_operands();

    sender_idle_pct = 76;
    receiver_idle_pct = 12;
    repeat (RANDOM_PER_PHASE) send_random_operands();

    // No idling; the result side holds off so that the input backs up.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_request = 1'b1;
    repeat (RANDOM_PER_PHASE) send_random_operands();
    in_valid_i <= 1'b0;

    while (sb.expected_powers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.failures == 0 && sb.expected_powers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
